[rtl/assert_macros.svh]
// assertion macros included by the rtl top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge out of reset
`define LAVM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lavm check failed");
// condition must never be seen out of reset
`define LAVM_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lavm forbidden condition");
`else
`define LAVM_ASSERT(label, prop)
`define LAVM_NEVER(label, cond)
`endif

`endif

[rtl/lavm_pkg.sv]
// types, constants and arithmetic helpers of the look-at view matrix block
package lavm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int COL_W     = 18;
    localparam int UNIT_W    = FRAC_BITS + 2;
    localparam int VEC_W     = FRAC_BITS + 34;
    localparam int MAG_W     = VEC_W;
    localparam int POS_W     = $clog2(MAG_W);
    localparam int W_W       = 31;
    localparam int SQ_STEPS  = 32;
    localparam int QB        = FRAC_BITS + 1;
    localparam int NUM_W     = FRAC_BITS + 32;
    localparam int RW        = UNIT_W + 34;
    localparam int PW        = 2 * UNIT_W;
    localparam int TP_W      = UNIT_W + IN_W;
    localparam int IN_DATA_W  = 9 * IN_W;
    localparam int OUT_DATA_W = ((3 * COL_W + IN_W + 7) / 8) * 8;
    localparam int USER_W     = 3;
    localparam int ONE_INT    = 1 << FRAC_BITS;
    localparam int HALF_INT   = 1 << (FRAC_BITS - 1);

    localparam logic signed [RW-1:0] UNIT_ONE = RW'(ONE_INT);
    localparam logic [RW-1:0]        HALF     = RW'(HALF_INT);

    typedef logic signed [IN_W-1:0]   coord_t;
    typedef logic signed [UNIT_W-1:0] unit_t;
    typedef logic signed [VEC_W-1:0]  vec_t;

    typedef enum logic [1:0] {ROW_U, ROW_V, ROW_N} row_t;

    // data carried alongside a vector through a normalizer
    typedef struct packed {
        coord_t [2:0] eye;
        coord_t [2:0] up;
        unit_t  [2:0] n;
        logic         degen;
    } side_t;

    // shift right by the fraction width, half away from zero
    function automatic logic signed [RW-1:0] shr_round(input logic signed [RW-1:0] x);
        logic [RW-1:0] mag;
        logic [RW-1:0] r;
        mag = x[RW-1] ? RW'(-x) : RW'(x);
        r   = (mag + HALF) >> FRAC_BITS;
        return x[RW-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic unit_t clamp_unit(input logic signed [RW-1:0] x);
        logic signed [RW-1:0] c;
        c = x;
        if (x > UNIT_ONE)
            c = UNIT_ONE;
        else if (x < -UNIT_ONE)
            c = -UNIT_ONE;
        return UNIT_W'(c);
    endfunction

    function automatic coord_t sat32(input logic signed [RW-1:0] x);
        coord_t r;
        if ((&x[RW-1:IN_W-1]) || !(|x[RW-1:IN_W-1]))
            r = x[IN_W-1:0];
        else if (x[RW-1])
            r = {1'b1, {(IN_W-1){1'b0}}};
        else
            r = {1'b0, {(IN_W-1){1'b1}}};
        return r;
    endfunction

endpackage

[rtl/lavm_norm.sv]
// pipelined 3-vector normalizer: scale, sum of squares, square root, divide
module lavm_norm
    import lavm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  vec_t  [2:0]  in_vec,
    input  side_t        in_side,
    output logic         out_valid,
    output unit_t [2:0]  out_unit,
    output logic         out_zero,
    output side_t        out_side
);

    localparam int ST_E  = 4;
    localparam int ST_DV = ST_E + SQ_STEPS + 1;
    localparam int ST_Q  = ST_DV + QB;
    localparam int NST   = ST_Q + 1;

    typedef struct packed {
        side_t                     side;
        logic [2:0]                sgn;
        logic                      zero;
        logic [2:0][MAG_W-1:0]     mag;
        logic [POS_W-1:0]          pos;
        logic [2:0][W_W-1:0]       w;
        logic [2:0][2*W_W-1:0]     sq;
        logic [63:0]               rad;
        logic [33:0]               rem;
        logic [31:0]               root;
        logic [2:0][NUM_W-1:0]     num;
        logic [2:0][31:0]          drem;
        logic [2:0][QB-1:0]        quo;
    } nst_t;

    nst_t             st_reg  [NST];
    nst_t             st_next [NST];
    logic [NST-1:0]   vld_reg;
    logic [NST-1:0]   vld_next;
    logic             out_valid_reg;
    unit_t [2:0]      out_unit_reg;
    unit_t [2:0]      out_unit_next;
    logic             out_zero_reg;
    side_t            out_side_reg;

    always_comb
    begin
        logic [MAG_W-1:0]    ormag;
        logic [MAG_W+29:0]   wide;
        logic [35:0]         rr;
        logic [35:0]         tr;
        logic [32:0]         dr;
        logic [NUM_W-1:0]    nm;
        logic [QB-1:0]       q;
        for (int s = 1; s < NST; s++)
            st_next[s] = st_reg[s-1];
        // abs and signs
        st_next[0] = '0;
        st_next[0].side = in_side;
        for (int i = 0; i < 3; i++)
        begin
            st_next[0].sgn[i] = in_vec[i][VEC_W-1];
            st_next[0].mag[i] = in_vec[i][VEC_W-1] ? MAG_W'(-$signed(in_vec[i]))
                                                   : MAG_W'(in_vec[i]);
        end
        // leading one of the largest magnitude equals that of the or of all
        ormag = st_reg[0].mag[0] | st_reg[0].mag[1] | st_reg[0].mag[2];
        st_next[1].zero = (ormag == '0);
        st_next[1].pos  = '0;
        for (int b = 0; b < MAG_W; b++)
            if (ormag[b])
                st_next[1].pos = POS_W'(b);
        // move leading one to bit 30, right shifts truncate
        for (int i = 0; i < 3; i++)
        begin
            wide = {st_reg[1].mag[i], 30'b0} >> st_reg[1].pos;
            st_next[2].w[i] = wide[W_W-1:0];
        end
        for (int i = 0; i < 3; i++)
            st_next[3].sq[i] = {{W_W{1'b0}}, st_reg[2].w[i]} * {{W_W{1'b0}}, st_reg[2].w[i]};
        st_next[ST_E].rad  = 64'(st_reg[3].sq[0]) + 64'(st_reg[3].sq[1])
                           + 64'(st_reg[3].sq[2]);
        st_next[ST_E].rem  = '0;
        st_next[ST_E].root = '0;
        // square root, one result bit a stage
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            rr = {st_reg[ST_E+k].rem, st_reg[ST_E+k].rad[2*(SQ_STEPS-1-k) +: 2]};
            tr = {2'b00, st_reg[ST_E+k].root, 2'b01};
            if (rr >= tr)
            begin
                st_next[ST_E+1+k].rem  = 34'(rr - tr);
                st_next[ST_E+1+k].root = {st_reg[ST_E+k].root[30:0], 1'b1};
            end
            else
            begin
                st_next[ST_E+1+k].rem  = 34'(rr);
                st_next[ST_E+1+k].root = {st_reg[ST_E+k].root[30:0], 1'b0};
            end
        end
        // rounded dividend and top partial remainder
        for (int i = 0; i < 3; i++)
        begin
            nm = NUM_W'({st_reg[ST_DV-1].w[i], {FRAC_BITS{1'b0}}})
               + NUM_W'(st_reg[ST_DV-1].root >> 1);
            st_next[ST_DV].num[i]  = nm;
            st_next[ST_DV].drem[i] = 32'(nm >> QB);
            st_next[ST_DV].quo[i]  = '0;
        end
        // restoring division, one quotient bit a stage
        for (int t = 0; t < QB; t++)
            for (int i = 0; i < 3; i++)
            begin
                dr = {st_reg[ST_DV+t].drem[i], st_reg[ST_DV+t].num[i][QB-1-t]};
                if (dr >= {1'b0, st_reg[ST_DV+t].root})
                begin
                    st_next[ST_DV+1+t].drem[i]        = 32'(dr - {1'b0, st_reg[ST_DV+t].root});
                    st_next[ST_DV+1+t].quo[i][QB-1-t] = 1'b1;
                end
                else
                begin
                    st_next[ST_DV+1+t].drem[i] = 32'(dr);
                end
            end
        for (int i = 0; i < 3; i++)
        begin
            q = st_reg[ST_Q].quo[i];
            if (st_reg[ST_Q].zero)
                out_unit_next[i] = '0;
            else if (st_reg[ST_Q].sgn[i])
                out_unit_next[i] = -$signed(UNIT_W'(q));
            else
                out_unit_next[i] = UNIT_W'(q);
        end
    end

    assign vld_next = {vld_reg[NST-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NST; s++)
                st_reg[s] <= st_next[s];
            out_unit_reg <= out_unit_next;
            out_zero_reg <= st_reg[ST_Q].zero;
            out_side_reg <= st_reg[ST_Q].side;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_unit  = out_unit_reg;
    assign out_zero  = out_zero_reg;
    assign out_side  = out_side_reg;

endmodule

[rtl/look_at_view_matrix_top.sv]
// look-at view matrix: three matrix rows per eye, target and up beat
//
// channel   dir  handshake                    payload
// s_axis    in   s_tvalid / s_tready          s_tdata: eye, target, up
// m_axis    out  m_tvalid / m_tready / tlast  m_tdata: row, m_tuser: index, degenerate
//
// one input beat gives three output beats, one row a cycle while m_tready is high;
// no new beat is taken while rows are pending; the first row passes the input
// register, the view normalizer, the cross product register, the side normalizer
// and the v1, v2, t1, t2 and serializer registers; each normalizer takes 56 stages:
// 32 square root and 17 divide steps dominate; reset clears the valid bits and the
// row counter; a stall on m_tready holds the whole pipeline in place
`include "assert_macros.svh"

module look_at_view_matrix_top
    import lavm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // col_zero, col_one, col_two, col_three, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // row_index, degenerate
    output logic [USER_W-1:0]     m_tuser,
    output logic                  m_tlast
);

    logic               adv;

    logic               in_vld_reg;
    coord_t [2:0]       in_eye_reg;
    coord_t [2:0]       in_tgt_reg;
    coord_t [2:0]       in_up_reg;

    vec_t   [2:0]       n1_vec;
    side_t              n1_in_side;
    logic               n1_vld;
    unit_t  [2:0]       n1_unit;
    logic               n1_zero;
    side_t              n1_side;

    logic               x1_vld_reg;
    vec_t   [5:0]       x1_prod_reg;
    side_t              x1_side_reg;

    vec_t   [2:0]       n2_vec;
    logic               n2_vld;
    unit_t  [2:0]       n2_unit;
    logic               n2_zero;
    side_t              n2_side;

    logic               v1_vld_reg;
    logic [5:0][PW-1:0] v1_prod_reg;
    unit_t  [2:0]       v1_u_reg;
    unit_t  [2:0]       v1_n_reg;
    coord_t [2:0]       v1_eye_reg;
    logic               v1_degen_reg;

    logic               v2_vld_reg;
    unit_t  [2:0][2:0]  v2_rows_reg;
    unit_t  [2:0][2:0]  v2_rows_next;
    coord_t [2:0]       v2_eye_reg;
    logic               v2_degen_reg;

    logic                    t1_vld_reg;
    logic [2:0][2:0][TP_W-1:0] t1_prod_reg;
    unit_t  [2:0][2:0]       t1_rows_reg;
    logic                    t1_degen_reg;

    logic               t2_vld_reg;
    unit_t  [2:0][2:0]  t2_rows_reg;
    coord_t [2:0]       t2_trans_reg;
    coord_t [2:0]       t2_trans_next;
    logic               t2_degen_reg;

    logic               ser_vld_reg;
    row_t               row_reg;
    row_t               row_next;
    unit_t  [2:0][2:0]  ser_rows_reg;
    coord_t [2:0]       ser_trans_reg;
    logic               ser_degen_reg;

    // the pipeline moves when the serializer is empty or hands over its last row
    assign adv      = !ser_vld_reg || (m_tready && row_reg == ROW_N);
    assign s_tready = adv;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n1_vec[i] = VEC_W'($signed(in_eye_reg[i])) - VEC_W'($signed(in_tgt_reg[i]));
        n1_in_side.eye   = in_eye_reg;
        n1_in_side.up    = in_up_reg;
        n1_in_side.n     = '0;
        n1_in_side.degen = 1'b0;
    end

    lavm_norm u_norm_view (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_vld_reg),
        .in_vec    (n1_vec),
        .in_side   (n1_in_side),
        .out_valid (n1_vld),
        .out_unit  (n1_unit),
        .out_zero  (n1_zero),
        .out_side  (n1_side)
    );

    // side axis = up x n
    assign n2_vec[0] = x1_prod_reg[0] - x1_prod_reg[1];
    assign n2_vec[1] = x1_prod_reg[2] - x1_prod_reg[3];
    assign n2_vec[2] = x1_prod_reg[4] - x1_prod_reg[5];

    lavm_norm u_norm_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (x1_vld_reg),
        .in_vec    (n2_vec),
        .in_side   (x1_side_reg),
        .out_valid (n2_vld),
        .out_unit  (n2_unit),
        .out_zero  (n2_zero),
        .out_side  (n2_side)
    );

    always_comb
    begin
        logic signed [RW-1:0] raw;
        for (int i = 0; i < 3; i++)
        begin
            raw = RW'($signed(v1_prod_reg[2*i])) - RW'($signed(v1_prod_reg[2*i+1]));
            v2_rows_next[ROW_U][i] = v1_degen_reg ? '0 : v1_u_reg[i];
            v2_rows_next[ROW_V][i] = v1_degen_reg ? '0 : clamp_unit(shr_round(raw));
            v2_rows_next[ROW_N][i] = v1_degen_reg ? '0 : v1_n_reg[i];
        end
    end

    always_comb
    begin
        logic signed [RW-1:0] sum;
        for (int k = 0; k < 3; k++)
        begin
            sum = RW'($signed(t1_prod_reg[k][0])) + RW'($signed(t1_prod_reg[k][1]))
                + RW'($signed(t1_prod_reg[k][2]));
            t2_trans_next[k] = t1_degen_reg ? '0 : sat32(-shr_round(sum));
        end
    end

    always_comb
    begin
        row_next = row_reg;
        unique case (row_reg)
            ROW_U:   row_next = ROW_V;
            ROW_V:   row_next = ROW_N;
            ROW_N:   row_next = ROW_N;
            default: row_next = ROW_U;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            x1_vld_reg  <= 1'b0;
            v1_vld_reg  <= 1'b0;
            v2_vld_reg  <= 1'b0;
            t1_vld_reg  <= 1'b0;
            t2_vld_reg  <= 1'b0;
            ser_vld_reg <= 1'b0;
            row_reg     <= ROW_U;
        end
        else if (adv)
        begin
            in_vld_reg  <= s_tvalid;
            x1_vld_reg  <= n1_vld;
            v1_vld_reg  <= n2_vld;
            v2_vld_reg  <= v1_vld_reg;
            t1_vld_reg  <= v2_vld_reg;
            t2_vld_reg  <= t1_vld_reg;
            ser_vld_reg <= t2_vld_reg;
            row_reg     <= ROW_U;
        end
        else if (m_tready)
        begin
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                in_eye_reg[i] <= s_tdata[IN_W*i +: IN_W];
                in_tgt_reg[i] <= s_tdata[IN_W*(3+i) +: IN_W];
                in_up_reg[i]  <= s_tdata[IN_W*(6+i) +: IN_W];
            end

            x1_prod_reg[0] <= $signed(n1_side.up[1]) * $signed(n1_unit[2]);
            x1_prod_reg[1] <= $signed(n1_side.up[2]) * $signed(n1_unit[1]);
            x1_prod_reg[2] <= $signed(n1_side.up[2]) * $signed(n1_unit[0]);
            x1_prod_reg[3] <= $signed(n1_side.up[0]) * $signed(n1_unit[2]);
            x1_prod_reg[4] <= $signed(n1_side.up[0]) * $signed(n1_unit[1]);
            x1_prod_reg[5] <= $signed(n1_side.up[1]) * $signed(n1_unit[0]);
            x1_side_reg.eye   <= n1_side.eye;
            x1_side_reg.up    <= n1_side.up;
            x1_side_reg.n     <= n1_unit;
            x1_side_reg.degen <= n1_zero;

            // v = n x u
            v1_prod_reg[0] <= $signed(n2_side.n[1]) * $signed(n2_unit[2]);
            v1_prod_reg[1] <= $signed(n2_side.n[2]) * $signed(n2_unit[1]);
            v1_prod_reg[2] <= $signed(n2_side.n[2]) * $signed(n2_unit[0]);
            v1_prod_reg[3] <= $signed(n2_side.n[0]) * $signed(n2_unit[2]);
            v1_prod_reg[4] <= $signed(n2_side.n[0]) * $signed(n2_unit[1]);
            v1_prod_reg[5] <= $signed(n2_side.n[1]) * $signed(n2_unit[0]);
            v1_u_reg       <= n2_unit;
            v1_n_reg       <= n2_side.n;
            v1_eye_reg     <= n2_side.eye;
            v1_degen_reg   <= n2_side.degen || n2_zero;

            v2_rows_reg  <= v2_rows_next;
            v2_eye_reg   <= v1_eye_reg;
            v2_degen_reg <= v1_degen_reg;

            for (int k = 0; k < 3; k++)
                for (int i = 0; i < 3; i++)
                    t1_prod_reg[k][i] <= $signed(v2_rows_reg[k][i]) * $signed(v2_eye_reg[i]);
            t1_rows_reg  <= v2_rows_reg;
            t1_degen_reg <= v2_degen_reg;

            t2_rows_reg  <= t1_rows_reg;
            t2_trans_reg <= t2_trans_next;
            t2_degen_reg <= t1_degen_reg;

            ser_rows_reg  <= t2_rows_reg;
            ser_trans_reg <= t2_trans_reg;
            ser_degen_reg <= t2_degen_reg;
        end
    end

    assign m_tvalid = ser_vld_reg;
    assign m_tlast  = (row_reg == ROW_N);
    assign m_tuser  = {ser_degen_reg, row_reg};
    assign m_tdata  = {{(OUT_DATA_W - 3*COL_W - IN_W){1'b0}},
                       ser_trans_reg[row_reg],
                       COL_W'(ser_rows_reg[row_reg][2]),
                       COL_W'(ser_rows_reg[row_reg][1]),
                       COL_W'(ser_rows_reg[row_reg][0])};

    // no new beat while rows of the current matrix are still pending
    `LAVM_ASSERT(a_hold_input, (ser_vld_reg && row_reg != ROW_N) |-> !s_tready)
    // a degenerate matrix carries zero rows
    `LAVM_ASSERT(a_degen_zero, (m_tvalid && m_tuser[2]) |-> (m_tdata == '0))
    // output drains after the last row when nothing follows
    `LAVM_ASSERT(a_drain, (m_tvalid && m_tready && m_tlast && !t2_vld_reg) |=> !m_tvalid)

endmodule

[bench/tb_look_at_view_matrix_top.sv]
// testbench for the look-at view matrix block: directed and random camera beats
module tb_look_at_view_matrix_top;
    import lavm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCH_LIMIT = 20000;

    typedef struct {
        row_t        row;
        logic [17:0] c0;
        logic [17:0] c1;
        logic [17:0] c2;
        logic [31:0] c3;
        logic        degen;
        logic        last;
    } mat_row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [USER_W-1:0] m_tuser;
    logic m_tlast;

    mat_row_t expected_rows[$];
    int errors;
    int idle_cycles;
    bit hold_off;

    look_at_view_matrix_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic longint iabs(input longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint clamp1(input longint x);
        longint one;
        one = longint'(1) << FRAC_BITS;
        if (x > one) return one;
        if (x < -one) return -one;
        return x;
    endfunction

    function automatic longint round_shift(input longint x);
        longint r;
        r = (iabs(x) + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        return x < 0 ? -r : r;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // scale into [2^30, 2^31), then divide by integer length
    function automatic bit unit_vector(input longint vin[3], output longint vout[3]);
        longint w[3];
        longint mx;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned a;
        longint q;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            w[i] = vin[i];
            if (iabs(w[i]) > mx) mx = iabs(w[i]);
            vout[i] = 0;
        end
        if (mx == 0) return 0;
        while (mx < (longint'(1) << 30))
        begin
            for (int i = 0; i < 3; i++) w[i] = w[i] * 2;
            mx = mx * 2;
        end
        while (mx >= (longint'(1) << 31))
        begin
            for (int i = 0; i < 3; i++) w[i] = w[i] / 2;
            mx = mx / 2;
        end
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            a = iabs(w[i]);
            sum = sum + a * a;
        end
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            a = iabs(w[i]);
            q = longint'(((a << FRAC_BITS) + len / 2) / len);
            vout[i] = clamp1(w[i] < 0 ? -q : q);
        end
        return 1;
    endfunction

    function automatic void cross_prod(input longint a[3], input longint b[3],
                                       output longint r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic void predict_view_rows(input logic [IN_DATA_W-1:0] d);
        longint eye[3], dv[3], up[3], n[3], u[3], v[3], side[3], raw[3];
        longint mat[3][3];
        longint s, t;
        bit ok;
        mat_row_t r;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = longint'($signed(d[32*i +: 32]));
            dv[i] = eye[i] - longint'($signed(d[32*(3+i) +: 32]));
            up[i] = longint'($signed(d[32*(6+i) +: 32]));
            u[i] = 0;
            v[i] = 0;
        end
        ok = unit_vector(dv, n);
        if (ok)
        begin
            cross_prod(up, n, side);
            ok = unit_vector(side, u);
        end
        if (ok)
        begin
            cross_prod(n, u, raw);
            for (int i = 0; i < 3; i++) v[i] = clamp1(round_shift(raw[i]));
        end
        for (int i = 0; i < 3; i++)
        begin
            mat[0][i] = ok ? u[i] : 0;
            mat[1][i] = ok ? v[i] : 0;
            mat[2][i] = ok ? n[i] : 0;
        end
        for (int k = 0; k < 3; k++)
        begin
            s = mat[k][0] * eye[0] + mat[k][1] * eye[1] + mat[k][2] * eye[2];
            t = -round_shift(s);
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            r.row = row_t'(k);
            r.c0 = mat[k][0][17:0];
            r.c1 = mat[k][1][17:0];
            r.c2 = mat[k][2][17:0];
            r.c3 = ok ? t[31:0] : 32'd0;
            r.degen = !ok;
            r.last = (k == 2);
            expected_rows.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // valid only drops when a gap follows, so it never gets two updates in one step
    task automatic send_beat(input logic [IN_DATA_W-1:0] d);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_view_rows(d);
        @(negedge clk);
    endtask

    function automatic logic [IN_DATA_W-1:0] pack_beat(input logic [31:0] e[3],
            input logic [31:0] t[3], input logic [31:0] up[3]);
        return {up[2], up[1], up[0], t[2], t[1], t[0], e[2], e[1], e[0]};
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 * 65536 * 20)) - 65536 * 20);
            2: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
            3: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] e[3], t[3], up[3];
        // plain camera looking down -z
        e = '{32'h0, 32'h0, 32'h0005_0000};
        t = '{32'h0, 32'h0, 32'h0};
        up = '{32'h0, 32'h0001_0000, 32'h0};
        send_beat(pack_beat(e, t, up));
        // eye equals target
        t = e;
        send_beat(pack_beat(e, t, up));
        // up parallel to view axis
        t = '{32'h0, 32'h0, 32'h0};
        up = '{32'h0, 32'h0, 32'h0003_0000};
        send_beat(pack_beat(e, t, up));
        // up zero
        up = '{32'h0, 32'h0, 32'h0};
        send_beat(pack_beat(e, t, up));
        // extreme corners, saturating translation
        e = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        t = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        up = '{32'h8000_0000, 32'h7fff_ffff, 32'h0};
        send_beat(pack_beat(e, t, up));
        e = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        t = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        up = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
        send_beat(pack_beat(e, t, up));
        // tiny difference needs upscaling
        e = '{32'h1, 32'h0, 32'h0};
        t = '{32'h0, 32'h0, 32'h0};
        up = '{32'h0, 32'h0, 32'h1};
        send_beat(pack_beat(e, t, up));
        e = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
        up = '{32'hffff_ffff, 32'h1, 32'h1};
        send_beat(pack_beat(e, t, up));
        for (int i = 0; i < 12; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                e[j] = rand_coord();
                t[j] = rand_coord();
                up[j] = rand_coord();
            end
            send_beat(pack_beat(e, t, up));
        end
    endtask

    task automatic test_random(input int count);
        logic [31:0] e[3], t[3], up[3];
        for (int i = 0; i < count; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                e[j] = rand_coord();
                t[j] = $urandom_range(0, 15) == 0 ? e[j] : rand_coord();
                up[j] = rand_coord();
            end
            send_beat(pack_beat(e, t, up));
        end
    endtask

    // receiver holds off long enough for the pipeline to fill and block input
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            test_random(60);
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
        join
    endtask

    // receiver inserts a random wait after each accepted row beat
    initial
    begin
        int wait_left;
        wait_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                wait_left = $urandom_range(0, 15);
                if ($urandom_range(0, 1)) wait_left = 0;
            end
            @(negedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else if (wait_left > 0)
            begin
                m_tready <= 1'b0;
                wait_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        mat_row_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_rows.size() == 0)
                report_mismatch("unexpected row beat", m_tuser, 32'd0);
            else
            begin
                want = expected_rows.pop_front();
                if (m_tuser[1:0] !== want.row)
                    report_mismatch("row_index", m_tuser[1:0], want.row);
                if (m_tuser[2] !== want.degen)
                    report_mismatch("degenerate", m_tuser[2], want.degen);
                if (m_tlast !== want.last)
                    report_mismatch("last_row", m_tlast, want.last);
                if (m_tdata[17:0] !== want.c0)
                    report_mismatch("col_zero", m_tdata[17:0], want.c0);
                if (m_tdata[35:18] !== want.c1)
                    report_mismatch("col_one", m_tdata[35:18], want.c1);
                if (m_tdata[53:36] !== want.c2)
                    report_mismatch("col_two", m_tdata[53:36], want.c2);
                if (m_tdata[85:54] !== want.c3)
                    report_mismatch("col_three", m_tdata[85:54], want.c3);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT)
        begin
            $display("tb_look_at_view_matrix_top failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random(370);
        s_tvalid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb_look_at_view_matrix_top passed");
        else
            $display("tb_look_at_view_matrix_top failed");
        $finish;
    end
endmodule
